// ===== rtl/csl_pkg.sv =====
package csl_pkg;

  localparam int DEPTH_DEF     = 32;
  localparam int WORD_BITS_DEF = 32;

  // Fixed payload widths of the channels
  localparam int OPCODE_W  = 4;
  localparam int VALUE_W   = 32;
  localparam int POS_W     = 5;
  localparam int CNT_OUT_W = 6;
  localparam int STATUS_W  = 3;

  typedef enum logic [OPCODE_W-1:0] {
    OP_START        = 4'd0,
    OP_ADVANCE      = 4'd1,
    OP_TO_LAST      = 4'd2,
    OP_INSERT       = 4'd3,
    OP_ATTACH       = 4'd4,
    OP_PUT_FRONT    = 4'd5,
    OP_PUT_BACK     = 4'd6,
    OP_REMOVE_CUR   = 4'd7,
    OP_REMOVE_FRONT = 4'd8,
    OP_READ_CUR     = 4'd9,
    OP_READ_AT      = 4'd10
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 3'd0,
    ST_FULL   = 3'd1,
    ST_NO_CUR = 3'd2,
    ST_RANGE  = 3'd3,
    ST_EMPTY  = 3'd4
  } status_t;

  // Broadcast to every cell of the chain
  typedef struct packed {
    logic shift_up;   // open a slot at the given index
    logic shift_dn;   // close the slot at the given index
  } cell_ctrl_t;

endpackage

// ===== rtl/csl_req_if.sv =====
interface csl_req_if;
  import csl_pkg::*;

  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [VALUE_W-1:0]  entry_value;
  logic [POS_W-1:0]    position;

  modport source (output valid, opcode, entry_value, position, input ready);
  modport sink   (input valid, opcode, entry_value, position, output ready);
endinterface

// ===== rtl/csl_rsp_if.sv =====
interface csl_rsp_if;
  import csl_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [VALUE_W-1:0]   read_value;
  logic                 has_current;
  logic [CNT_OUT_W-1:0] cursor_pos;
  logic [CNT_OUT_W-1:0] item_count;
  logic [STATUS_W-1:0]  status;

  modport source (output valid, read_value, has_current, cursor_pos, item_count, status,
                  input ready);
  modport sink   (input valid, read_value, has_current, cursor_pos, item_count, status,
                  output ready);
endinterface

// ===== rtl/csl_cell.sv =====
module csl_cell #(
  parameter int WORD_BITS = csl_pkg::WORD_BITS_DEF,
  parameter int AW        = 5,
  parameter int INDEX     = 0
) (
  input  logic                 clk,
  input  csl_pkg::cell_ctrl_t  ctrl,
  input  logic [AW-1:0]        at,
  input  logic [WORD_BITS-1:0] word,
  input  logic [WORD_BITS-1:0] from_lo,
  input  logic [WORD_BITS-1:0] from_hi,
  output logic [WORD_BITS-1:0] data
);
  import csl_pkg::*;

  localparam logic [AW-1:0] MY_IDX = AW'(INDEX);

  logic [WORD_BITS-1:0] data_next;

  always_comb begin
    data_next = data;
    if (ctrl.shift_up) begin
      if (MY_IDX > at) begin
        data_next = from_lo;
      end else if (MY_IDX == at) begin
        data_next = word;
      end
    end else if (ctrl.shift_dn) begin
      if (MY_IDX >= at) begin
        data_next = from_hi;
      end
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

// ===== rtl/cursor_sequence_list.sv =====
// Ordered list of up to DEPTH words with a cursor, held in a chain of cells that
// shift up or down together on an insert or a remove. One operation is taken per
// cycle unless a result waits untaken; each result sits in an output register in
// the cycle after the request beat, and a new request is taken in the cycle the
// result is taken. The cycle path is the per-cell shift select plus the read mux
// over all cells. Entries above the count hold stale data and are never returned;
// no clearing pass is needed after reset. On any error status nothing in the list changes.
module cursor_sequence_list #(
  parameter int DEPTH     = csl_pkg::DEPTH_DEF,
  parameter int WORD_BITS = csl_pkg::WORD_BITS_DEF
) (
  input logic      clk,
  input logic      rst,
  csl_req_if.sink  req,
  csl_rsp_if.source rsp
);
  import csl_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;

  logic [CW-1:0] count, count_next;
  logic [CW-1:0] cursor, cursor_next;

  logic                 out_valid;
  logic [VALUE_W-1:0]   out_value;
  logic                 out_has_cur;
  logic [CNT_OUT_W-1:0] out_cursor;
  logic [CNT_OUT_W-1:0] out_count;
  status_t              out_status;

  logic [WORD_BITS-1:0] cell_data [DEPTH];
  logic [WORD_BITS-1:0] word;
  cell_ctrl_t           ctrl;
  logic [AW-1:0]        at;
  logic [AW-1:0]        rd_addr;
  logic                 rd_en;
  logic [WORD_BITS-1:0] rd_word;
  status_t              status_next;
  op_t                  op;
  logic                 accept;
  logic                 cur;
  logic                 full;

  assign req.ready = !out_valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign op        = op_t'(req.opcode);
  assign word      = WORD_BITS'(req.entry_value);
  assign cur       = cursor < count;
  assign full      = count == CW'(DEPTH);
  assign rd_word   = cell_data[rd_addr];

  always_comb begin
    count_next  = count;
    cursor_next = cursor;
    status_next = ST_OK;
    ctrl        = '0;
    at          = '0;
    rd_addr     = AW'(cursor);
    rd_en       = 1'b0;
    case (op)
      OP_START: begin
        cursor_next = '0;
      end
      OP_ADVANCE: begin
        if (!cur) status_next = ST_NO_CUR;
        else cursor_next = cursor + CW'(1);
      end
      OP_TO_LAST: begin
        if (count == '0) status_next = ST_EMPTY;
        else cursor_next = count - CW'(1);
      end
      OP_INSERT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          at            = cur ? AW'(cursor) : '0;
          ctrl.shift_up = 1'b1;
          count_next    = count + CW'(1);
          cursor_next   = cur ? cursor : '0;
        end
      end
      OP_ATTACH: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          cursor_next   = cur ? cursor + CW'(1) : count;
          at            = AW'(cursor_next);
          ctrl.shift_up = 1'b1;
          count_next    = count + CW'(1);
        end
      end
      OP_PUT_FRONT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          ctrl.shift_up = 1'b1;
          count_next    = count + CW'(1);
          cursor_next   = cursor + CW'(1);
        end
      end
      OP_PUT_BACK: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          at            = AW'(count);
          ctrl.shift_up = 1'b1;
          count_next    = count + CW'(1);
          // no current item stays no current item
          if (!cur) cursor_next = count + CW'(1);
        end
      end
      OP_REMOVE_CUR: begin
        if (!cur) begin
          status_next = ST_NO_CUR;
        end else begin
          at            = AW'(cursor);
          ctrl.shift_dn = 1'b1;
          count_next    = count - CW'(1);
        end
      end
      OP_REMOVE_FRONT: begin
        if (count == '0) begin
          status_next = ST_EMPTY;
        end else begin
          ctrl.shift_dn = 1'b1;
          count_next    = count - CW'(1);
          if (cursor != '0) cursor_next = cursor - CW'(1);
        end
      end
      OP_READ_CUR: begin
        if (!cur) status_next = ST_NO_CUR;
        else rd_en = 1'b1;
      end
      OP_READ_AT: begin
        rd_addr = AW'(req.position);
        if (PW'(req.position) >= PW'(count)) status_next = ST_RANGE;
        else rd_en = 1'b1;
      end
      default: begin
      end
    endcase
    if (!accept) ctrl = '0;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_BITS-1:0] lo;
    logic [WORD_BITS-1:0] hi;
    if (i == 0) begin : g_lo_end
      assign lo = word;
    end else begin : g_lo
      assign lo = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_hi_end
      assign hi = cell_data[i];
    end else begin : g_hi
      assign hi = cell_data[i+1];
    end
    csl_cell #(
      .WORD_BITS (WORD_BITS),
      .AW        (AW),
      .INDEX     (i)
    ) u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .at      (at),
      .word    (word),
      .from_lo (lo),
      .from_hi (hi),
      .data    (cell_data[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      cursor    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        cursor    <= cursor_next;
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_value   <= rd_en ? VALUE_W'(rd_word) : '0;
      out_has_cur <= cursor_next < count_next;
      out_cursor  <= CNT_OUT_W'(cursor_next);
      out_count   <= CNT_OUT_W'(count_next);
      out_status  <= status_next;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.read_value  = out_value;
  assign rsp.has_current = out_has_cur;
  assign rsp.cursor_pos  = out_cursor;
  assign rsp.item_count  = out_count;
  assign rsp.status      = out_status;

  a_cursor_le_count: assert property (@(posedge clk) disable iff (rst)
    cursor <= count)
    else $error("cursor past count");

  a_count_le_depth: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("count past depth");

  a_err_no_change: assert property (@(posedge clk) disable iff (rst)
    accept && status_next != ST_OK |=> count == $past(count) && cursor == $past(cursor))
    else $error("state changed on error beat");

  a_err_no_shift: assert property (@(posedge clk) disable iff (rst)
    status_next != ST_OK |-> !ctrl.shift_up && !ctrl.shift_dn)
    else $error("cells shifted on error");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("result beat missing");

endmodule

// ===== sim/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import csl_pkg::*;

  localparam int DEPTH = DEPTH_DEF;
  localparam logic [OPCODE_W-1:0] OP_FIRST_SPARE = OPCODE_W'(OP_READ_AT + 1);
  localparam logic [OPCODE_W-1:0] OP_LAST_SPARE  = '1;
  localparam op_t GROW_OPS [4] = '{OP_INSERT, OP_ATTACH, OP_PUT_FRONT, OP_PUT_BACK};
  localparam op_t SHRINK_OPS [2] = '{OP_REMOVE_CUR, OP_REMOVE_FRONT};
  localparam op_t WALK_OPS [5] = '{OP_START, OP_ADVANCE, OP_TO_LAST, OP_READ_CUR, OP_READ_AT};

  typedef struct packed {
    logic [VALUE_W-1:0]   read_value;
    logic                 has_current;
    logic [CNT_OUT_W-1:0] cursor_pos;
    logic [CNT_OUT_W-1:0] item_count;
    status_t              status;
  } list_reply_t;

  logic clk;
  logic rst;

  csl_req_if req ();
  csl_rsp_if rsp ();

  cursor_sequence_list dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // shadow copy of the list
  logic [VALUE_W-1:0] shadow_list [DEPTH];
  int unsigned        shadow_count;
  int unsigned        shadow_cursor;

  list_reply_t pending_replies [$];
  int unsigned failures;
  int unsigned reply_idx;

  int unsigned gap_pct;
  int unsigned stall_pct;
  int unsigned hold_request;
  bit          filling;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void open_slot(int unsigned at, logic [VALUE_W-1:0] word);
    for (int unsigned i = shadow_count; i > at; i--) shadow_list[i] = shadow_list[i-1];
    shadow_list[at] = word;
    shadow_count++;
  endfunction

  function automatic void close_slot(int unsigned at);
    for (int unsigned i = at; i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i+1];
    shadow_count--;
  endfunction

  function automatic list_reply_t apply_list_op(logic [OPCODE_W-1:0] opc,
                                                logic [VALUE_W-1:0] word,
                                                logic [POS_W-1:0] pos);
    list_reply_t res;
    bit          has_cur;
    bit          full;
    int unsigned at;
    has_cur = shadow_cursor < shadow_count;
    full    = shadow_count >= DEPTH;
    res.read_value = '0;
    res.status     = ST_OK;
    case (opc)
      OP_START: shadow_cursor = 0;
      OP_ADVANCE: begin
        if (!has_cur) res.status = ST_NO_CUR;
        else shadow_cursor++;
      end
      OP_TO_LAST: begin
        if (shadow_count == 0) res.status = ST_EMPTY;
        else shadow_cursor = shadow_count - 1;
      end
      OP_INSERT: begin
        if (full) res.status = ST_FULL;
        else begin
          at = has_cur ? shadow_cursor : 0;
          open_slot(at, word);
          shadow_cursor = at;
        end
      end
      OP_ATTACH: begin
        if (full) res.status = ST_FULL;
        else begin
          at = has_cur ? shadow_cursor + 1 : shadow_count;
          open_slot(at, word);
          shadow_cursor = at;
        end
      end
      OP_PUT_FRONT: begin
        if (full) res.status = ST_FULL;
        else begin
          open_slot(0, word);
          shadow_cursor++;
        end
      end
      OP_PUT_BACK: begin
        if (full) res.status = ST_FULL;
        else begin
          open_slot(shadow_count, word);
          if (!has_cur) shadow_cursor = shadow_count;
        end
      end
      OP_REMOVE_CUR: begin
        if (!has_cur) res.status = ST_NO_CUR;
        else close_slot(shadow_cursor);
      end
      OP_REMOVE_FRONT: begin
        if (shadow_count == 0) res.status = ST_EMPTY;
        else begin
          close_slot(0);
          if (shadow_cursor > 0) shadow_cursor--;
        end
      end
      OP_READ_CUR: begin
        if (!has_cur) res.status = ST_NO_CUR;
        else res.read_value = shadow_list[shadow_cursor];
      end
      OP_READ_AT: begin
        if (pos >= shadow_count) res.status = ST_RANGE;
        else res.read_value = shadow_list[pos];
      end
      default: ;
    endcase
    res.has_current = shadow_cursor < shadow_count;
    res.cursor_pos  = CNT_OUT_W'(shadow_cursor);
    res.item_count  = CNT_OUT_W'(shadow_count);
    return res;
  endfunction

  // valid stays high across back-to-back beats; it only drops ahead of a gap
  task automatic send_item(logic [OPCODE_W-1:0] opc, logic [VALUE_W-1:0] word,
                           logic [POS_W-1:0] pos);
    int unsigned gap;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      gap = pick_gap();
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid       <= 1'b1;
    req.opcode      <= opc;
    req.entry_value <= word;
    req.position    <= pos;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    pending_replies.push_back(apply_list_op(opc, word, pos));
  endtask

  // biased toward growing or shrinking so the list sweeps between empty and full
  task automatic send_random_item();
    int unsigned        r;
    int unsigned        grow_pct;
    int unsigned        shrink_pct;
    logic [OPCODE_W-1:0] opc;
    logic [VALUE_W-1:0]  word;
    logic [POS_W-1:0]    pos;
    grow_pct   = filling ? 55 : 10;
    shrink_pct = filling ? 10 : 55;
    r = $urandom_range(0, 99);
    if (r < 3) opc = OPCODE_W'($urandom_range(OP_FIRST_SPARE, OP_LAST_SPARE));
    else if (r < 3 + grow_pct) opc = GROW_OPS[$urandom_range(0, 3)];
    else if (r < 3 + grow_pct + shrink_pct) opc = SHRINK_OPS[$urandom_range(0, 1)];
    else opc = WALK_OPS[$urandom_range(0, 4)];
    case ($urandom_range(0, 15))
      0: word = '0;
      1: word = '1;
      default: word = $urandom;
    endcase
    if (shadow_count > 0 && $urandom_range(0, 3) != 0)
      pos = POS_W'($urandom_range(0, shadow_count - 1));
    else
      pos = POS_W'($urandom_range(0, 31));
    send_item(opc, word, pos);
    if (shadow_count == DEPTH && filling && $urandom_range(0, 3) == 0) filling = 1'b0;
    else if (shadow_count == 0 && !filling && $urandom_range(0, 3) == 0) filling = 1'b1;
  endtask

  task automatic test_empty_list();
    send_item(OP_START, '0, '0);
    send_item(OP_ADVANCE, '0, '0);
    send_item(OP_TO_LAST, '0, '0);
    send_item(OP_REMOVE_CUR, '0, '0);
    send_item(OP_REMOVE_FRONT, '0, '0);
    send_item(OP_READ_CUR, '0, '0);
    send_item(OP_READ_AT, '0, '0);
    send_item(OP_LAST_SPARE, '1, '1);
    send_item(OP_FIRST_SPARE, '0, '0);
  endtask

  task automatic test_each_operation();
    send_item(OP_PUT_BACK, '0, '0);          // no current item stays none
    send_item(OP_PUT_FRONT, '1, '0);
    send_item(OP_START, '0, '0);
    send_item(OP_READ_CUR, '0, '0);
    send_item(OP_ATTACH, 32'hA5A5_A5A5, '0);
    send_item(OP_INSERT, 32'h5A5A_5A5A, '0);
    send_item(OP_ADVANCE, '0, '0);
    send_item(OP_TO_LAST, '0, '0);
    send_item(OP_ADVANCE, '0, '0);           // steps off the end
    send_item(OP_INSERT, 32'h0000_0001, '0); // no current: goes to the front
    send_item(OP_REMOVE_FRONT, '0, '0);      // cursor on front: new front current
    send_item(OP_TO_LAST, '0, '0);
    send_item(OP_REMOVE_CUR, '0, '0);        // last removed: no current
    send_item(OP_ATTACH, 32'h8000_0000, '0); // no current: goes to the back
    send_item(OP_READ_AT, '0, '1);
    send_item(OP_READ_AT, '0, '0);
    send_item(OP_REMOVE_FRONT, '0, '0);
    send_item(OP_START, '0, '0);
    send_item(OP_REMOVE_CUR, '0, '0);
  endtask

  task automatic test_full_input_stall();
    gap_pct = 0;
    hold_request = 80;
    repeat (16) send_random_item();
    gap_pct = 30;
  endtask

  task automatic test_random_lists(int unsigned n);
    repeat (n) send_random_item();
  endtask

  task automatic test_back_to_back(int unsigned n);
    gap_pct   = 0;
    stall_pct = 0;
    repeat (n) send_random_item();
    gap_pct   = 30;
    stall_pct = 30;
  endtask

  // receiver: random stalls plus an occasional long hold-off
  initial begin
    int unsigned stall_left;
    int unsigned hold_left;
    stall_left = 0;
    hold_left  = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        rsp.ready <= 1'b0;
        hold_left--;
      end else if (stall_left != 0) begin
        rsp.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp.ready <= 1'b1;
        if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) stall_left = pick_gap();
      end
    end
  end

  task automatic note_mismatch(string field, logic [VALUE_W-1:0] want_v,
                               logic [VALUE_W-1:0] got_v);
    failures++;
    if (failures <= 10)
      $display("reply %0d: %s expected %0h, got %0h", reply_idx, field, want_v, got_v);
  endtask

  always @(posedge clk) begin
    list_reply_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_replies.size() == 0) begin
        failures++;
        if (failures <= 10) $display("reply %0d: unexpected beat", reply_idx);
      end else begin
        want = pending_replies.pop_front();
        if (rsp.read_value !== want.read_value)
          note_mismatch("read_value", want.read_value, rsp.read_value);
        if (rsp.has_current !== want.has_current)
          note_mismatch("has_current", VALUE_W'(want.has_current),
                        VALUE_W'(rsp.has_current));
        if (rsp.cursor_pos !== want.cursor_pos)
          note_mismatch("cursor_pos", VALUE_W'(want.cursor_pos), VALUE_W'(rsp.cursor_pos));
        if (rsp.item_count !== want.item_count)
          note_mismatch("item_count", VALUE_W'(want.item_count), VALUE_W'(rsp.item_count));
        if (rsp.status !== want.status)
          note_mismatch("status", VALUE_W'(want.status), VALUE_W'(rsp.status));
      end
      reply_idx++;
    end
  end

  initial begin
    failures      = 0;
    reply_idx     = 0;
    shadow_count  = 0;
    shadow_cursor = 0;
    gap_pct       = 30;
    stall_pct     = 30;
    hold_request  = 0;
    filling       = 1'b1;
    rst             <= 1'b1;
    req.valid       <= 1'b0;
    req.opcode      <= '0;
    req.entry_value <= '0;
    req.position    <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_list();
    test_each_operation();
    test_full_input_stall();
    test_random_lists(540);
    test_back_to_back(150);

    req.valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
